// File: rtl/core/owm_pkg.sv
// Types, constants and helpers shared by the single-wire bus master core.
// No dependencies; used by owm_cfg_regs, owm_seq and one_wire_bus_master_core.
`timescale 1ns / 1ps

package owm_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_REGS   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRE_HIGH  = 3'd0,
    CFG_RST_LOW   = 3'd1,
    CFG_PDELAY    = 3'd2,
    CFG_PTIMEOUT  = 3'd3,
    CFG_RECOVERY  = 3'd4,
    CFG_SLOT      = 3'd5,
    CFG_WRITE_LOW = 3'd6,
    CFG_READ_LOW  = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_PRE     = 4'd1,
    PH_RST_LOW = 4'd2,
    PH_PDELAY  = 4'd3,
    PH_PWAIT   = 4'd4,
    PH_RECOV   = 4'd5,
    PH_WLOW    = 4'd6,
    PH_WDATA   = 4'd7,
    PH_RLOW    = 4'd8,
    PH_RDATA   = 4'd9
  } phase_t;

  localparam cfg_word_t CFG_RESET [CFG_REGS] = '{
    16'd10, 16'd600, 16'd100, 16'd480, 16'd400, 16'd60, 16'd2, 16'd5
  };

  typedef struct packed {
    timer_t pre;
    timer_t rst_low;
    timer_t pdelay;
    timer_t pwait;
    timer_t recov;
    timer_t slot;
    timer_t wlow;
    timer_t rlow;
  } len_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] write_data;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [7:0] read_byte;
    logic       presence;
  } res_t;

  // Clamp a register value to the timer range, optionally forcing at least one tick.
  function automatic timer_t clamp_len(input cfg_word_t v, input logic min_one);
    logic [31:0] w;
    w = 32'(v);
    if (w > TIMER_MAX) w = TIMER_MAX;
    if (min_one && (w == 32'd0)) w = 32'd1;
    return w[TIMER_BITS-1:0];
  endfunction

endpackage

// File: rtl/core/owm_cfg_regs.sv
// Timing register file of the bus master; presents clamped phase lengths.
// Depends on owm_pkg.
`timescale 1ns / 1ps

module owm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output owm_pkg::len_t                   len
);

  owm_pkg::cfg_word_t cfg_r [owm_pkg::CFG_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < owm_pkg::CFG_REGS; i++) begin
        cfg_r[i] <= owm_pkg::CFG_RESET[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    len.pre     = owm_pkg::clamp_len(cfg_r[owm_pkg::CFG_PRE_HIGH],  1'b0);
    len.rst_low = owm_pkg::clamp_len(cfg_r[owm_pkg::CFG_RST_LOW],   1'b1);
    len.pdelay  = owm_pkg::clamp_len(cfg_r[owm_pkg::CFG_PDELAY],    1'b0);
    len.pwait   = owm_pkg::clamp_len(cfg_r[owm_pkg::CFG_PTIMEOUT],  1'b1);
    len.recov   = owm_pkg::clamp_len(cfg_r[owm_pkg::CFG_RECOVERY],  1'b0);
    len.slot    = owm_pkg::clamp_len(cfg_r[owm_pkg::CFG_SLOT],      1'b1);
    len.wlow    = owm_pkg::clamp_len(cfg_r[owm_pkg::CFG_WRITE_LOW], 1'b1);
    len.rlow    = owm_pkg::clamp_len(cfg_r[owm_pkg::CFG_READ_LOW],  1'b1);
  end

endmodule

// File: rtl/core/owm_seq.sv
// Bus sequencer: phase, tick timer, bit counter and shift byte, advanced one tick per step.
// Depends on owm_pkg; lengths come from owm_cfg_regs.
`timescale 1ns / 1ps

module owm_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  owm_pkg::item_t item,
  input  owm_pkg::len_t  len,
  output owm_pkg::res_t  res
);

  owm_pkg::phase_t phase_r, phase_nxt;
  owm_pkg::timer_t tick_r, tick_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic            pres_r, pres_nxt;
  logic [7:0]      last_read_r, last_read_nxt;

  function automatic owm_pkg::timer_t phase_len(input owm_pkg::phase_t p,
                                                input owm_pkg::len_t l);
    owm_pkg::timer_t v;
    case (p)
      owm_pkg::PH_PRE:     v = l.pre;
      owm_pkg::PH_RST_LOW: v = l.rst_low;
      owm_pkg::PH_PDELAY:  v = l.pdelay;
      owm_pkg::PH_PWAIT:   v = l.pwait;
      owm_pkg::PH_RECOV:   v = l.recov;
      owm_pkg::PH_WDATA:   v = l.slot;
      owm_pkg::PH_RDATA:   v = l.slot;
      owm_pkg::PH_WLOW:    v = l.wlow;
      owm_pkg::PH_RLOW:    v = l.rlow;
      default:             v = owm_pkg::timer_t'(1);
    endcase
    return v;
  endfunction

  // Skippable phases of zero length fall through to the following phase.
  function automatic owm_pkg::phase_t enter(input owm_pkg::phase_t p,
                                            input owm_pkg::len_t l);
    owm_pkg::phase_t q;
    q = p;
    if (p == owm_pkg::PH_PRE && l.pre == '0) q = owm_pkg::PH_RST_LOW;
    else if (p == owm_pkg::PH_PDELAY && l.pdelay == '0) q = owm_pkg::PH_PWAIT;
    else if (p == owm_pkg::PH_RECOV && l.recov == '0) q = owm_pkg::PH_IDLE;
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= owm_pkg::PH_IDLE;
      tick_r      <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      pres_r      <= 1'b0;
      last_read_r <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      pres_r      <= pres_nxt;
      last_read_r <= last_read_nxt;
    end
  end

  always_comb begin
    owm_pkg::phase_t           ph;
    logic [owm_pkg::TIMER_BITS:0] cnt;
    logic                      ends;
    logic                      busy;
    logic                      drive;

    ph            = phase_r;
    tick_nxt      = tick_r;
    bit_nxt       = bit_r;
    shift_nxt     = shift_r;
    pres_nxt      = pres_r;
    last_read_nxt = last_read_r;
    drive         = 1'b0;

    if (phase_r == owm_pkg::PH_IDLE && item.opcode != owm_pkg::OP_NONE) begin
      bit_nxt  = '0;
      tick_nxt = '0;
      case (item.opcode)
        owm_pkg::OP_RESET: begin
          pres_nxt = 1'b0;
          ph       = enter(owm_pkg::PH_PRE, len);
        end
        owm_pkg::OP_WRITE: begin
          shift_nxt = item.write_data;
          ph        = owm_pkg::PH_WLOW;
        end
        default: begin
          shift_nxt = '0;
          ph        = owm_pkg::PH_RLOW;
        end
      endcase
    end

    busy      = (ph != owm_pkg::PH_IDLE);
    cnt       = {1'b0, tick_nxt} + {{owm_pkg::TIMER_BITS{1'b0}}, 1'b1};
    ends      = (cnt >= {1'b0, phase_len(ph, len)});
    phase_nxt = ph;
    if (!ends) tick_nxt = cnt[owm_pkg::TIMER_BITS-1:0];

    case (ph)
      owm_pkg::PH_IDLE: begin
        tick_nxt = tick_r;
        if (phase_r == owm_pkg::PH_IDLE && item.opcode != owm_pkg::OP_NONE) tick_nxt = '0;
      end
      owm_pkg::PH_PRE: begin
        if (ends) phase_nxt = owm_pkg::PH_RST_LOW;
      end
      owm_pkg::PH_RST_LOW: begin
        drive = 1'b1;
        if (ends) phase_nxt = enter(owm_pkg::PH_PDELAY, len);
      end
      owm_pkg::PH_PDELAY: begin
        if (ends) phase_nxt = owm_pkg::PH_PWAIT;
      end
      owm_pkg::PH_PWAIT: begin
        if (!item.line_level) begin
          pres_nxt  = 1'b1;
          phase_nxt = enter(owm_pkg::PH_RECOV, len);
          tick_nxt  = '0;
        end else if (ends) begin
          phase_nxt = enter(owm_pkg::PH_RECOV, len);
        end
      end
      owm_pkg::PH_RECOV: begin
        if (ends) phase_nxt = owm_pkg::PH_IDLE;
      end
      owm_pkg::PH_WLOW: begin
        drive = 1'b1;
        if (ends) phase_nxt = owm_pkg::PH_WDATA;
      end
      owm_pkg::PH_WDATA: begin
        drive = ~shift_nxt[0];
        if (ends) begin
          shift_nxt = {1'b0, shift_nxt[7:1]};
          if (bit_nxt == 3'd7) begin
            phase_nxt = owm_pkg::PH_IDLE;
          end else begin
            bit_nxt   = bit_nxt + 3'd1;
            phase_nxt = owm_pkg::PH_WLOW;
          end
        end
      end
      owm_pkg::PH_RLOW: begin
        drive = 1'b1;
        if (ends) phase_nxt = owm_pkg::PH_RDATA;
      end
      owm_pkg::PH_RDATA: begin
        if (tick_r == '0) shift_nxt = {item.line_level, shift_nxt[7:1]};
        if (ends) begin
          if (bit_nxt == 3'd7) begin
            last_read_nxt = shift_nxt;
            phase_nxt     = owm_pkg::PH_IDLE;
          end else begin
            bit_nxt   = bit_nxt + 3'd1;
            phase_nxt = owm_pkg::PH_RLOW;
          end
        end
      end
      default: begin
        phase_nxt = owm_pkg::PH_IDLE;
        tick_nxt  = '0;
      end
    endcase

    if (ends && ph != owm_pkg::PH_IDLE) tick_nxt = '0;

    res.drive_low = drive;
    res.busy      = busy;
    res.done      = busy && (phase_nxt == owm_pkg::PH_IDLE);
    res.read_byte = last_read_nxt;
    res.presence  = pres_nxt;
  end

endmodule

// File: rtl/core/one_wire_bus_master_core.sv
// Top level of the single-wire bus master: input register, sequencer, result register.
// Depends on owm_pkg, owm_cfg_regs and owm_seq.
`timescale 1ns / 1ps
//
// Usage:
//   Each input transfer (in_valid high, in_stall low) is one microsecond tick.
//   It carries the sampled bus level and, while the master is idle, a command:
//   bus reset, write byte (in_write_data, LSB first) or read byte.
//   Each tick yields exactly one result transfer: line drive, busy, a done
//   pulse on the last tick of a command, the last read byte and presence.
//   Timing registers are written on the cfg_ channel (cfg_ready is always high);
//   the user writes them only while no tick is in flight; the block does not enforce it.
// Flow and throughput:
//   A tick waits in the input register; its result goes to the result register and out_ ports.
//   One tick per cycle is sustained while out_stall is low; the sequencer state advances
//   once per tick between the input and result registers.
// Reset:
//   Synchronous, active low. Both stages empty, sequencer idle, all timing
//   registers back to their defaults, read byte and presence cleared.
// Stall:
//   While out_stall holds a result, one more tick waits in the input register;
//   after that in_stall rises until the result is taken.
//
module one_wire_bus_master_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_opcode,
  input  logic [7:0]                      in_write_data,
  input  logic                            in_line_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_drive_low,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic [7:0]                      out_read_byte,
  output logic                            out_presence_seen,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  owm_pkg::item_t item_r, item_nxt;
  logic           item_valid_r, item_valid_nxt;
  owm_pkg::res_t  res_r, res_nxt;
  logic           res_valid_r, res_valid_nxt;
  owm_pkg::len_t  len;
  logic           advance;
  logic           in_xfer;

  owm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .len       (len)
  );

  owm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .len   (len),
    .res   (res_nxt)
  );

  assign advance  = item_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = in_xfer || (item_valid_r && !advance);
    res_valid_nxt  = advance || (res_valid_r && out_stall);
    item_nxt       = item_r;
    if (in_xfer) begin
      item_nxt.opcode     = owm_pkg::op_t'(in_opcode);
      item_nxt.write_data = in_write_data;
      item_nxt.line_level = in_line_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (advance) res_r <= res_nxt;
  end

  assign out_valid         = res_valid_r;
  assign out_drive_low     = res_r.drive_low;
  assign out_busy_res      = res_r.busy;
  assign out_done_res      = res_r.done;
  assign out_read_byte     = res_r.read_byte;
  assign out_presence_seen = res_r.presence;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid_r)
    else $error("input stalled with empty input register");

  a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.done |-> res_r.busy)
    else $error("done result without busy");

  a_drive_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.drive_low |-> res_r.busy)
    else $error("line driven low while idle");

  a_no_item_lost: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && res_valid_r && out_stall |=> item_valid_r)
    else $error("stalled tick dropped from input register");
`endif

endmodule
